FILE: hw/rtl/debounced_keyboard_midi_encoder_top_assert.svh
// assertion macros for the keyboard midi encoder checker
`ifndef DEBOUNCED_KEYBOARD_MIDI_ENCODER_TOP_ASSERT_SVH
`define DEBOUNCED_KEYBOARD_MIDI_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define DKME_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, also checked during reset
`define DKME_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: hw/rtl/dkme_pkg.sv
// shared types and constants of the keyboard midi encoder
package dkme_pkg;

   localparam int IDX_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL  = 3'd3;

   localparam logic [3:0] SW_OCT_UP    = 4'd0;
   localparam logic [3:0] SW_OCT_DOWN  = 4'd1;
   localparam logic [3:0] SW_TUNE_DOWN = 4'd4;
   localparam logic [3:0] SW_TUNE_UP   = 4'd5;
   localparam logic [3:0] SW_AUDIO     = 4'd6;

   localparam logic [1:0] TONE_NONE  = 2'd0;
   localparam logic [1:0] TONE_START = 2'd1;
   localparam logic [1:0] TONE_STOP  = 2'd2;

   localparam logic [1:0] LED_YELLOW = 2'd0;
   localparam logic [1:0] LED_GREEN  = 2'd1;
   localparam logic [1:0] LED_RED    = 2'd2;

   localparam logic [7:0] ST_NOTE_ON  = 8'h90;
   localparam logic [7:0] ST_NOTE_OFF = 8'h80;

   localparam logic signed [3:0] OCT_MAX  = 4'sd5;
   localparam logic signed [3:0] OCT_MIN  = 4'sb1011;
   localparam logic signed [6:0] TUNE_MAX = 7'sd63;
   localparam logic signed [6:0] TUNE_MIN = 7'sb1000000;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [6:0]  BASE_RESET     = 7'd60;
   localparam logic [6:0]  VELOCITY_RESET = 7'd110;
   localparam logic [3:0]  CHANNEL_RESET  = 4'd0;

   typedef struct packed {
      logic        raw;
      logic        stable;
      logic [31:0] change_time;
   } line_state_type;

   localparam line_state_type LINE_RESET = '{raw: 1'b1, stable: 1'b1, change_time: 32'd0};

endpackage

FILE: hw/rtl/dkme_ram.sv
// generic single-write single-read ram with registered read
module dkme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/debounced_keyboard_midi_encoder_top.sv
// top level of the debounced keyboard scanner and midi encoder
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | line index, raw level, timestamp
//   rsp     | out       | rsp_valid/rsp_ready | midi message, tone action, status
//   csr     | in        | csr_valid/csr_ready | register index, write data
//
// one sample per cycle unless the update stage is held: the line ram is read at the
// accepting edge; write-back and output register load happen at the edge where it fires.
// a sample whose line was written at its accepting edge takes the write-back data.
// per-line valid flops stand in for the line reset.
// a full output register holds the update stage and with it req_ready.
module debounced_keyboard_midi_encoder_top #(
   parameter int KEY_COUNT    = 13,
   parameter int SWITCH_COUNT = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [4:0]                       req_line_index,
   input  logic                             req_line_level,
   input  logic [31:0]                      req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_midi_valid,
   output logic [7:0]                       rsp_midi_status,
   output logic [6:0]                       rsp_midi_note,
   output logic [6:0]                       rsp_midi_velocity,
   output logic [1:0]                       rsp_tone_action,
   output logic [6:0]                       rsp_tone_note,
   output logic signed [3:0]                rsp_octave_now,
   output logic                             rsp_audio_on,
   output logic signed [6:0]                rsp_tuning_hz,
   output logic [1:0]                       rsp_led_colour,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dkme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dkme_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int LINE_COUNT = KEY_COUNT + SWITCH_COUNT;
   localparam int ADDR_W     = $clog2(LINE_COUNT);
   localparam int EXT_W      = (ADDR_W > dkme_pkg::IDX_W) ? ADDR_W : dkme_pkg::IDX_W;
   localparam int ENTRY_W    = $bits(dkme_pkg::line_state_type);

   // configuration
   logic [15:0] debounce_ff;
   logic [6:0]  base_ff;
   logic [6:0]  velocity_ff;
   logic [3:0]  channel_ff;

   // input decode
   logic              req_accept;
   logic [EXT_W-1:0]  req_line_ext;
   logic              req_in_range;
   logic [ADDR_W-1:0] req_addr;

   // update stage
   logic              s1_valid_ff;
   logic [4:0]        s1_line_ff;
   logic [EXT_W-1:0]  s1_line_ext_ff;
   logic              s1_in_range_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_level_ff;
   logic [31:0]       s1_now_ff;
   logic              s1_hit_ff;
   logic              s2_fire;

   // line memory and bypass
   logic                     entry_valid_ff [LINE_COUNT];
   logic [ENTRY_W-1:0]       rd_data;
   logic                     wr_en;
   dkme_pkg::line_state_type wr_entry;
   dkme_pkg::line_state_type bypass_ff;
   dkme_pkg::line_state_type cur_entry;

   // global state
   logic signed [3:0] oct_ff, oct_in;
   logic              audio_ff, audio_in;
   logic signed [6:0] tune_ff, tune_in;
   logic              last_valid_ff, last_valid_in;
   logic [6:0]        last_note_ff, last_note_in;

   // step result
   logic              settle;
   logic [31:0]       new_time;
   logic [31:0]       elapsed;
   logic              is_key;
   logic [EXT_W-1:0]  sw_ext;
   logic [3:0]        sw_code;
   logic signed [9:0] oct_ext;
   logic signed [9:0] oct_x12;
   logic signed [9:0] note_sum;
   logic              note_ok;
   logic [6:0]        note;
   logic              res;
   logic              midi_valid;
   logic [7:0]        midi_status;
   logic [6:0]        midi_velocity;
   logic [6:0]        midi_note;
   logic [1:0]        tone_action;
   logic [6:0]        tone_note;
   logic [1:0]        led;

   // output register
   logic              rsp_valid_ff;
   logic              midi_valid_ff;
   logic [7:0]        midi_status_ff;
   logic [6:0]        midi_note_ff;
   logic [6:0]        midi_velocity_ff;
   logic [1:0]        tone_action_ff;
   logic [6:0]        tone_note_ff;
   logic signed [3:0] octave_now_ff;
   logic              audio_on_ff;
   logic signed [6:0] tuning_hz_ff;
   logic [1:0]        led_colour_ff;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= dkme_pkg::DEBOUNCE_RESET;
         base_ff     <= dkme_pkg::BASE_RESET;
         velocity_ff <= dkme_pkg::VELOCITY_RESET;
         channel_ff  <= dkme_pkg::CHANNEL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            dkme_pkg::CSR_DEBOUNCE: debounce_ff <= csr_data;
            dkme_pkg::CSR_BASE:     base_ff     <= csr_data[6:0];
            dkme_pkg::CSR_VELOCITY: velocity_ff <= csr_data[6:0];
            dkme_pkg::CSR_CHANNEL:  channel_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign s2_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s2_fire;
   assign req_accept = req_valid && req_ready;

   assign req_line_ext = EXT_W'(req_line_index);
   assign req_in_range = req_line_ext < EXT_W'(LINE_COUNT);
   assign req_addr     = req_in_range ? req_line_ext[ADDR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_line_ff     <= req_line_index;
         s1_line_ext_ff <= req_line_ext;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         s1_level_ff    <= req_line_level;
         s1_now_ff      <= req_now_ms;
         s1_hit_ff      <= wr_en && (req_addr == s1_addr_ff);
      end
      if (wr_en) begin
         bypass_ff <= wr_entry;
      end
   end

   dkme_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LINE_COUNT)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_entry),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_COUNT; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         entry_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // current line state with forwarding of the previous write-back
   always_comb begin
      if (s1_hit_ff) begin
         cur_entry = bypass_ff;
      end else if (entry_valid_ff[s1_addr_ff]) begin
         cur_entry = dkme_pkg::line_state_type'(rd_data);
      end else begin
         cur_entry = dkme_pkg::LINE_RESET;
      end
   end

   // debounce
   assign new_time = (s1_level_ff != cur_entry.raw) ? s1_now_ff : cur_entry.change_time;
   assign elapsed  = s1_now_ff - new_time;
   assign settle   = (elapsed > {16'd0, debounce_ff}) && (s1_level_ff != cur_entry.stable);

   assign wr_en                = s2_fire && s1_in_range_ff;
   assign wr_entry.raw         = s1_level_ff;
   assign wr_entry.stable      = settle ? s1_level_ff : cur_entry.stable;
   assign wr_entry.change_time = new_time;

   // note number and switch code
   assign is_key   = s1_line_ext_ff < EXT_W'(KEY_COUNT);
   assign sw_ext   = s1_line_ext_ff - EXT_W'(KEY_COUNT);
   assign sw_code  = sw_ext[3:0];
   assign oct_ext  = 10'(oct_ff);
   assign oct_x12  = oct_ext * 10'sd12;
   assign note_sum = $signed({3'b000, base_ff}) + $signed({5'b00000, s1_line_ff}) + oct_x12;
   assign note_ok  = (note_sum[9:7] == 3'b000);
   assign note     = note_sum[6:0];

   always_comb begin
      oct_in        = oct_ff;
      audio_in      = audio_ff;
      tune_in       = tune_ff;
      last_valid_in = last_valid_ff;
      last_note_in  = last_note_ff;
      res           = 1'b0;
      midi_valid    = 1'b0;
      midi_status   = 8'd0;
      midi_note     = 7'd0;
      midi_velocity = 7'd0;
      tone_action   = dkme_pkg::TONE_NONE;
      tone_note     = 7'd0;
      if (s1_in_range_ff && settle) begin
         if (is_key) begin
            if (note_ok) begin
               res        = 1'b1;
               midi_valid = 1'b1;
               midi_note  = note;
               if (!s1_level_ff) begin
                  midi_status   = dkme_pkg::ST_NOTE_ON | {4'h0, channel_ff};
                  midi_velocity = velocity_ff;
                  last_valid_in = 1'b1;
                  last_note_in  = note;
                  if (audio_ff) begin
                     tone_action = dkme_pkg::TONE_START;
                     tone_note   = note;
                  end
               end else begin
                  midi_status = dkme_pkg::ST_NOTE_OFF | {4'h0, channel_ff};
                  if (last_valid_ff && (last_note_ff == note)) begin
                     tone_action   = dkme_pkg::TONE_STOP;
                     last_valid_in = 1'b0;
                     last_note_in  = 7'd0;
                  end
               end
            end
         end else if (!s1_level_ff) begin
            case (sw_code)
               dkme_pkg::SW_OCT_UP: begin
                  if (oct_ff != dkme_pkg::OCT_MAX) begin
                     oct_in      = oct_ff + 4'sd1;
                     tone_action = dkme_pkg::TONE_STOP;
                     res         = 1'b1;
                  end
               end
               dkme_pkg::SW_OCT_DOWN: begin
                  if (oct_ff != dkme_pkg::OCT_MIN) begin
                     oct_in      = oct_ff - 4'sd1;
                     tone_action = dkme_pkg::TONE_STOP;
                     res         = 1'b1;
                  end
               end
               dkme_pkg::SW_TUNE_DOWN: begin
                  if (tune_ff != dkme_pkg::TUNE_MIN) begin
                     tune_in = tune_ff - 7'sd1;
                  end
                  res = 1'b1;
               end
               dkme_pkg::SW_TUNE_UP: begin
                  if (tune_ff != dkme_pkg::TUNE_MAX) begin
                     tune_in = tune_ff + 7'sd1;
                  end
                  res = 1'b1;
               end
               dkme_pkg::SW_AUDIO: begin
                  audio_in = !audio_ff;
                  if (audio_ff) begin
                     tone_action = dkme_pkg::TONE_STOP;
                  end
                  res = 1'b1;
               end
               default: ;
            endcase
            if (tone_action == dkme_pkg::TONE_STOP) begin
               last_valid_in = 1'b0;
               last_note_in  = 7'd0;
            end
         end
      end
   end

   always_comb begin
      if (tune_in == 7'sd0) begin
         led = dkme_pkg::LED_YELLOW;
      end else if (tune_in[6]) begin
         led = dkme_pkg::LED_RED;
      end else begin
         led = dkme_pkg::LED_GREEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff        <= 4'sd0;
         audio_ff      <= 1'b1;
         tune_ff       <= 7'sd0;
         last_valid_ff <= 1'b0;
         last_note_ff  <= 7'd0;
      end else if (s2_fire) begin
         oct_ff        <= oct_in;
         audio_ff      <= audio_in;
         tune_ff       <= tune_in;
         last_valid_ff <= last_valid_in;
         last_note_ff  <= last_note_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_fire && res) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && res) begin
         midi_valid_ff    <= midi_valid;
         midi_status_ff   <= midi_status;
         midi_note_ff     <= midi_note;
         midi_velocity_ff <= midi_velocity;
         tone_action_ff   <= tone_action;
         tone_note_ff     <= tone_note;
         octave_now_ff    <= oct_in;
         audio_on_ff      <= audio_in;
         tuning_hz_ff     <= tune_in;
         led_colour_ff    <= led;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_midi_valid    = midi_valid_ff;
   assign rsp_midi_status   = midi_status_ff;
   assign rsp_midi_note     = midi_note_ff;
   assign rsp_midi_velocity = midi_velocity_ff;
   assign rsp_tone_action   = tone_action_ff;
   assign rsp_tone_note     = tone_note_ff;
   assign rsp_octave_now    = octave_now_ff;
   assign rsp_audio_on      = audio_on_ff;
   assign rsp_tuning_hz     = tuning_hz_ff;
   assign rsp_led_colour    = led_colour_ff;

endmodule

FILE: hw/rtl/dkme_checker.sv
// port-level checks of the keyboard midi encoder and their binding
`include "debounced_keyboard_midi_encoder_top_assert.svh"

module dkme_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_midi_valid,
   input logic [7:0]          rsp_midi_status,
   input logic [6:0]          rsp_midi_note,
   input logic [6:0]          rsp_midi_velocity,
   input logic [1:0]          rsp_tone_action,
   input logic [6:0]          rsp_tone_note,
   input logic signed [6:0]   rsp_tuning_hz
);

   logic        rsp_stall;
   logic [15:0] rsp_held_fields;
   logic        msg_clear;
   logic        tone_start;
   logic        note_on_tone;

   assign rsp_stall       = !reset && rsp_valid && !rsp_ready;
   assign rsp_held_fields = {rsp_midi_note, rsp_tone_action, rsp_tuning_hz};
   assign msg_clear       = (rsp_midi_status == 8'd0) && (rsp_midi_note == 7'd0) &&
                            (rsp_midi_velocity == 7'd0);
   assign tone_start      = rsp_valid && (rsp_tone_action == dkme_pkg::TONE_START);
   assign note_on_tone    = rsp_midi_valid &&
                            (rsp_midi_status[7:4] == dkme_pkg::ST_NOTE_ON[7:4]) &&
                            (rsp_tone_note == rsp_midi_note);

   // no transaction left over from before reset
   `DKME_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // a stalled result keeps its note, tone action and tuning fields
   `DKME_ASSERT_NEXT(a_rsp_hold, clock, rsp_stall, rsp_valid && $stable(rsp_held_fields))

   // switch results carry a cleared message
   `DKME_ASSERT_IMPL(a_no_midi_zero, clock, reset, rsp_valid && !rsp_midi_valid, msg_clear)

   // a started tone comes with the note-on of the same note
   `DKME_ASSERT_IMPL(a_tone_start, clock, reset, tone_start, note_on_tone)

endmodule

bind debounced_keyboard_midi_encoder_top dkme_checker u_dkme_checker (.*);

FILE: sim/tb_debounced_keyboard_midi_encoder_top.sv
// self-checking testbench for the debounced keyboard scanner and midi encoder
module tb_debounced_keyboard_midi_encoder_top;

   localparam int KEY_COUNT    = 13;
   localparam int SWITCH_COUNT = 7;
   localparam int LINE_COUNT   = KEY_COUNT + SWITCH_COUNT;
   localparam int LINE_AUDIO   = KEY_COUNT + int'(dkme_pkg::SW_AUDIO);
   localparam int LINE_OCT_UP  = KEY_COUNT + int'(dkme_pkg::SW_OCT_UP);
   localparam int LINE_OCT_DN  = KEY_COUNT + int'(dkme_pkg::SW_OCT_DOWN);
   localparam int LINE_TUNE_DN = KEY_COUNT + int'(dkme_pkg::SW_TUNE_DOWN);
   localparam int LINE_TUNE_UP = KEY_COUNT + int'(dkme_pkg::SW_TUNE_UP);
   localparam int LINE_SPARE   = KEY_COUNT + 2;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [dkme_pkg::CSR_IDX_W-1:0] CSR_NONE_FIRST = dkme_pkg::CSR_CHANNEL + 1'b1;
   localparam logic [dkme_pkg::CSR_IDX_W-1:0] CSR_NONE_LAST  = '1;

   typedef struct packed {
      logic [4:0]  line;
      logic        level;
      logic [31:0] now;
   } sample_type;

   typedef struct packed {
      logic              midi_valid;
      logic [7:0]        midi_status;
      logic [6:0]        midi_note;
      logic [6:0]        midi_velocity;
      logic [1:0]        tone_action;
      logic [6:0]        tone_note;
      logic signed [3:0] octave_now;
      logic              audio_on;
      logic signed [6:0] tuning_hz;
      logic [1:0]        led_colour;
   } note_event_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [4:0]                      req_line_index = '0;
   logic                            req_line_level = 1'b1;
   logic [31:0]                     req_now_ms = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_midi_valid;
   logic [7:0]                      rsp_midi_status;
   logic [6:0]                      rsp_midi_note;
   logic [6:0]                      rsp_midi_velocity;
   logic [1:0]                      rsp_tone_action;
   logic [6:0]                      rsp_tone_note;
   logic signed [3:0]               rsp_octave_now;
   logic                            rsp_audio_on;
   logic signed [6:0]               rsp_tuning_hz;
   logic [1:0]                      rsp_led_colour;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dkme_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dkme_pkg::CSR_DATA_W-1:0] csr_data = '0;

   debounced_keyboard_midi_encoder_top #(
      .KEY_COUNT   (KEY_COUNT),
      .SWITCH_COUNT(SWITCH_COUNT)
   ) uut (.*);

   // scanner model state and register copies
   logic        raw_seen [LINE_COUNT];
   logic        settled [LINE_COUNT];
   logic [31:0] changed_at [LINE_COUNT];
   int          octave;
   logic        audio;
   int          tuning;
   logic        last_valid;
   int          last_note;
   logic [15:0] cfg_debounce;
   logic [6:0]  cfg_base;
   logic [6:0]  cfg_velocity;
   logic [3:0]  cfg_channel;

   sample_type     samples_to_send[$];
   note_event_type pending_events[$];
   sample_type     in_flight;
   note_event_type predicted;
   note_event_type want;
   logic           sender_free;
   int             send_idle = 38;
   int             recv_idle = 80;
   int             errors = 0;
   int             results_seen = 0;
   int             hold_left = 0;
   int             clock_count = 0;
   int             live_samples = 0;
   logic [31:0]    scan_ms = '0;
   logic           held [LINE_COUNT];

   initial forever #1 clock = ~clock;

   task automatic reset_model();
      for (int i = 0; i < LINE_COUNT; i++) begin
         raw_seen[i] = 1'b1;
         settled[i] = 1'b1;
         changed_at[i] = '0;
         held[i] = 1'b0;
      end
      octave = 0;
      audio = 1'b1;
      tuning = 0;
      last_valid = 1'b0;
      last_note = 0;
      cfg_debounce = dkme_pkg::DEBOUNCE_RESET;
      cfg_base = dkme_pkg::BASE_RESET;
      cfg_velocity = dkme_pkg::VELOCITY_RESET;
      cfg_channel = dkme_pkg::CHANNEL_RESET;
   endtask

   function automatic logic encode_sample(input sample_type s, output note_event_type ev);
      int         note;
      int         line;
      logic [1:0] act;
      logic       hit;
      ev = '0;
      hit = 1'b0;
      line = s.line;
      if (line >= LINE_COUNT) return 1'b0;
      if (s.level != raw_seen[line]) changed_at[line] = s.now;
      if (s.now - changed_at[line] > {16'd0, cfg_debounce} && s.level != settled[line]) begin
         settled[line] = s.level;
         if (line < KEY_COUNT) begin
            note = int'(cfg_base) + line + 12 * octave;
            if (note >= 0 && note <= 127) begin
               hit = 1'b1;
               ev.midi_valid = 1'b1;
               ev.midi_note = note[6:0];
               if (s.level == 1'b0) begin
                  last_valid = 1'b1;
                  last_note = note;
                  ev.midi_status = dkme_pkg::ST_NOTE_ON | {4'd0, cfg_channel};
                  ev.midi_velocity = cfg_velocity;
                  if (audio) begin
                     ev.tone_action = dkme_pkg::TONE_START;
                     ev.tone_note = note[6:0];
                  end
               end else begin
                  ev.midi_status = dkme_pkg::ST_NOTE_OFF | {4'd0, cfg_channel};
                  if (last_valid && last_note == note) begin
                     ev.tone_action = dkme_pkg::TONE_STOP;
                     last_valid = 1'b0;
                     last_note = 0;
                  end
               end
            end
         end else if (s.level == 1'b0) begin
            hit = 1'b1;
            act = dkme_pkg::TONE_NONE;
            case (4'(line - KEY_COUNT))
               dkme_pkg::SW_OCT_UP: begin
                  if (octave >= int'(dkme_pkg::OCT_MAX)) hit = 1'b0;
                  else begin
                     octave++;
                     act = dkme_pkg::TONE_STOP;
                  end
               end
               dkme_pkg::SW_OCT_DOWN: begin
                  if (octave <= int'(dkme_pkg::OCT_MIN)) hit = 1'b0;
                  else begin
                     octave--;
                     act = dkme_pkg::TONE_STOP;
                  end
               end
               dkme_pkg::SW_TUNE_DOWN: if (tuning > int'(dkme_pkg::TUNE_MIN)) tuning--;
               dkme_pkg::SW_TUNE_UP: if (tuning < int'(dkme_pkg::TUNE_MAX)) tuning++;
               dkme_pkg::SW_AUDIO: begin
                  audio = !audio;
                  if (!audio) act = dkme_pkg::TONE_STOP;
               end
               default: hit = 1'b0;
            endcase
            if (hit && act == dkme_pkg::TONE_STOP) begin
               last_valid = 1'b0;
               last_note = 0;
            end
            ev.tone_action = act;
         end
      end
      raw_seen[line] = s.level;
      ev.octave_now = 4'(octave);
      ev.audio_on = audio;
      ev.tuning_hz = 7'(tuning);
      ev.led_colour = tuning == 0 ? dkme_pkg::LED_YELLOW :
                      (tuning > 0 ? dkme_pkg::LED_GREEN : dkme_pkg::LED_RED);
      return hit;
   endfunction

   task automatic flag_error(input string what);
      errors++;
      $display("MISMATCH at cycle %0d: %s", clock_count, what);
   endtask

   task automatic compare_field(input string field, input logic [7:0] got,
                                input logic [7:0] exp_val);
      if (got !== exp_val)
         flag_error($sformatf("%s got 0x%02h expected 0x%02h", field, got, exp_val));
   endtask

   // driver: one transaction in flight, valid held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sender_free = !req_valid;
         if (req_valid && req_ready) begin
            if (encode_sample(in_flight, predicted)) pending_events.push_back(predicted);
            sender_free = 1'b1;
         end
         if (sender_free && samples_to_send.size() != 0 &&
             $urandom_range(0, 99) >= send_idle) begin
            in_flight = samples_to_send.pop_front();
            req_valid <= 1'b1;
            req_line_index <= in_flight.line;
            req_line_level <= in_flight.level;
            req_now_ms <= in_flight.now;
         end else if (sender_free) begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         results_seen++;
         if (results_seen == 100 || results_seen == 700) hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: checks each result transaction and drives back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               flag_error("result transaction with nothing pending");
            end else begin
               want = pending_events.pop_front();
               compare_field("midi_valid", rsp_midi_valid, want.midi_valid);
               compare_field("midi_status", rsp_midi_status, want.midi_status);
               compare_field("midi_note", rsp_midi_note, want.midi_note);
               compare_field("midi_velocity", rsp_midi_velocity, want.midi_velocity);
               compare_field("tone_action", rsp_tone_action, want.tone_action);
               compare_field("tone_note", rsp_tone_note, want.tone_note);
               compare_field("octave_now", rsp_octave_now, want.octave_now);
               compare_field("audio_on", rsp_audio_on, want.audio_on);
               compare_field("tuning_hz", rsp_tuning_hz, want.tuning_hz);
               compare_field("led_colour", rsp_led_colour, want.led_colour);
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= recv_idle;
         end
      end
   end

   always @(posedge clock) begin
      clock_count++;
      if (clock_count == CYCLE_LIMIT) begin
         $display("debounced_keyboard_midi_encoder_top verification failed");
         $finish;
      end
   end

   task automatic queue_sample(input int line, input logic level, input logic [31:0] stamp);
      samples_to_send.push_back('{line: 5'(line), level: level, now: stamp});
      if (line < LINE_COUNT) live_samples++;
   endtask

   // change to a new level, optional contact bounce, then a sample past the debounce time
   task automatic drive_transition(input int line, input logic lvl, input int bounces);
      scan_ms += $urandom_range(1, 5);
      queue_sample(line, lvl, scan_ms);
      repeat (bounces) begin
         scan_ms += $urandom_range(0, 3);
         queue_sample(line, !lvl, scan_ms);
         scan_ms += $urandom_range(0, 3);
         queue_sample(line, lvl, scan_ms);
      end
      scan_ms += cfg_debounce + 1 + $urandom_range(0, 3);
      queue_sample(line, lvl, scan_ms);
   endtask

   task automatic wait_drained();
      while (samples_to_send.size() != 0 || req_valid || pending_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [dkme_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dkme_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dkme_pkg::CSR_DEBOUNCE: cfg_debounce = value;
         dkme_pkg::CSR_BASE: cfg_base = value[6:0];
         dkme_pkg::CSR_VELOCITY: cfg_velocity = value[6:0];
         dkme_pkg::CSR_CHANNEL: cfg_channel = value[3:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [15:0] deb, input logic [15:0] base,
                            input logic [15:0] vel, input logic [15:0] chan,
                            input int items, input int focus, input int focus_pct,
                            input int s_idle, input int r_idle);
      int   line;
      int   start;
      int   pick;
      logic lvl;
      csr_write(dkme_pkg::CSR_DEBOUNCE, deb);
      csr_write(dkme_pkg::CSR_BASE, base);
      csr_write(dkme_pkg::CSR_VELOCITY, vel);
      csr_write(dkme_pkg::CSR_CHANNEL, chan);
      csr_write(CSR_NONE_FIRST, 16'($urandom));
      csr_write(CSR_NONE_LAST, 16'($urandom));
      csr_valid <= 1'b0;
      send_idle = s_idle;
      recv_idle = r_idle;
      start = live_samples;
      while (live_samples - start < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // noise, including ignored lines and arbitrary timestamps
            line = $urandom_range(0, 31);
            if ($urandom_range(0, 3) == 0) scan_ms = $urandom;
            else scan_ms += $urandom_range(0, cfg_debounce / 2 + 3);
            queue_sample(line, 1'($urandom_range(0, 1)), scan_ms);
         end else if (pick < 15) begin
            // second sample lands exactly on the debounce time
            line = $urandom_range(0, LINE_COUNT - 1);
            lvl = 1'($urandom_range(0, 1));
            scan_ms += $urandom_range(1, 5);
            queue_sample(line, lvl, scan_ms);
            scan_ms += cfg_debounce;
            queue_sample(line, lvl, scan_ms);
         end else begin
            if (focus >= 0 && $urandom_range(0, 99) < focus_pct) line = focus;
            else if ($urandom_range(0, 3) == 0) line = $urandom_range(KEY_COUNT, LINE_COUNT - 1);
            else line = $urandom_range(0, KEY_COUNT - 1);
            held[line] = !held[line];
            drive_transition(line, !held[line], line == focus ? 0 : $urandom_range(0, 2));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: debounce boundary, notes, tone stop on last note, switches, wrap
      queue_sample(0, 1'b0, 32'd0);
      queue_sample(0, 1'b0, 32'd50);
      queue_sample(0, 1'b0, 32'd51);
      queue_sample(12, 1'b0, 32'd100);
      queue_sample(12, 1'b0, 32'd200);
      queue_sample(0, 1'b1, 32'd210);
      queue_sample(0, 1'b1, 32'd300);
      queue_sample(12, 1'b1, 32'd310);
      queue_sample(12, 1'b1, 32'd400);
      queue_sample(LINE_AUDIO, 1'b0, 32'd410);
      queue_sample(LINE_AUDIO, 1'b0, 32'd500);
      queue_sample(LINE_SPARE, 1'b0, 32'd510);
      queue_sample(LINE_SPARE, 1'b0, 32'd600);
      queue_sample(31, 1'b0, 32'hFFFF_FFFF);
      queue_sample(LINE_OCT_UP, 1'b0, 32'd610);
      queue_sample(LINE_OCT_UP, 1'b0, 32'd700);
      queue_sample(LINE_TUNE_DN, 1'b0, 32'd710);
      queue_sample(LINE_TUNE_DN, 1'b0, 32'd800);
      queue_sample(LINE_TUNE_UP, 1'b0, 32'd810);
      queue_sample(LINE_TUNE_UP, 1'b0, 32'd900);
      queue_sample(LINE_OCT_DN, 1'b0, 32'd910);
      queue_sample(LINE_OCT_DN, 1'b0, 32'd1000);
      queue_sample(5, 1'b0, 32'hFFFF_FFFF);
      queue_sample(5, 1'b0, 32'h0000_0033);
      held[LINE_AUDIO] = 1'b1;
      held[LINE_SPARE] = 1'b1;
      held[LINE_OCT_UP] = 1'b1;
      held[LINE_TUNE_DN] = 1'b1;
      held[LINE_TUNE_UP] = 1'b1;
      held[LINE_OCT_DN] = 1'b1;
      held[5] = 1'b1;
      scan_ms = 32'd2000;
      wait_drained();

      run_phase(16'd0, 16'hFF80, 16'hFFFF, 16'hFFFF, 450, LINE_TUNE_DN, 85, 38, 80);
      run_phase(16'hFFFF, 16'd127, 16'd0, 16'd0, 300, LINE_OCT_DN, 40, 38, 80);
      run_phase(16'd1, 16'd60, 16'd64, 16'd9, 450, LINE_TUNE_UP, 85, 80, 38);
      run_phase(16'd7, 16'd5, 16'd1, 16'h0FF1, 400, LINE_TUNE_UP, 90, 80, 38);
      run_phase(16'd20, 16'd100, 16'd110, 16'd3, 350, LINE_OCT_UP, 40, 0, 0);

      if (errors == 0) begin
         $display("debounced_keyboard_midi_encoder_top verification clean");
      end else begin
         $display("debounced_keyboard_midi_encoder_top verification failed");
      end
      $finish;
   end

endmodule
